// File: sv/cdi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdi_pkg
// shared types, constants and helpers for the indexed circular deque
// ----------------------------------------------------------------------------
package cdi_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;

  localparam int ADDR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int SUM_W   = CNT_W + 1;
  localparam int CMD_W   = 3;
  localparam int IDX_W   = 4;
  localparam int FIELD_W = 32;
  localparam int CNT_OUT_W = 5;
  localparam int CMP_W   = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_GET        = 3'd0,
    CMD_PUT        = 3'd1,
    CMD_PUSH_FRONT = 3'd2,
    CMD_PUSH_BACK  = 3'd3,
    CMD_POP_FRONT  = 3'd4,
    CMD_POP_BACK   = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [IDX_W-1:0]   index;
    logic [FIELD_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [FIELD_W-1:0]   data;
    status_t              status;
    logic [CNT_OUT_W-1:0] count;
  } rsp_t;

  typedef struct packed {
    logic                  we;
    logic                  re;
    logic [ADDR_W-1:0]     addr;
    logic [DATA_WIDTH-1:0] wdata;
  } ram_req_t;

  typedef struct packed {
    logic               valid;
    logic               use_mem;
    logic [FIELD_W-1:0] imm_data;
    status_t            status;
    logic [CNT_W-1:0]   count;
  } pend_t;

  // physical slot of a logical offset, offset never above capacity minus one
  function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] head,
                                                input logic [CNT_W-1:0]  off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(head) + SUM_W'(off);
    if (sum >= SUM_W'(CAPACITY)) begin
      sum = sum - SUM_W'(CAPACITY);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

// File: sv/cdi_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdi_ram
// ring store, one port, registered read with read-before-write
// ----------------------------------------------------------------------------
module cdi_ram
  import cdi_pkg::*;
(
  input  logic                  clk,
  input  ram_req_t              req,
  output logic [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

// File: sv/cdi_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdi_ctrl
// command decode, head and fill pointers, ring store access
// ----------------------------------------------------------------------------
module cdi_ctrl
  import cdi_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  input  req_t     req,
  output logic     req_stall,
  input  logic     out_busy,
  output ram_req_t ram_req,
  output pend_t    pend
);

  logic [ADDR_W-1:0] head;
  logic [ADDR_W-1:0] head_next;
  logic [CNT_W-1:0]  fill;
  logic [CNT_W-1:0]  fill_next;
  logic              take;
  logic              idx_ok;
  pend_t             res;
  ram_req_t          op;

  assign req_stall = pend.valid | out_busy;
  assign take      = req_valid & ~req_stall;
  assign idx_ok    = CMP_W'(req.index) < CMP_W'(fill);

  always_comb begin
    head_next    = head;
    fill_next    = fill;
    op.we        = 1'b0;
    op.re        = 1'b0;
    op.addr      = slot_of(head, CNT_W'(req.index));
    op.wdata     = DATA_WIDTH'(req.value);
    res.valid    = 1'b1;
    res.use_mem  = 1'b0;
    res.imm_data = '0;
    res.status   = ST_OK;
    case (req.cmd)
      CMD_GET, CMD_PUT: begin
        if (!idx_ok) begin
          res.status = ST_RANGE;
        end else begin
          op.re       = 1'b1;
          op.we       = (req.cmd == CMD_PUT);
          res.use_mem = 1'b1;
        end
      end
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (fill == CNT_W'(CAPACITY)) begin
          res.status = ST_FULL;
        end else begin
          op.we        = 1'b1;
          fill_next    = fill + CNT_W'(1);
          res.imm_data = FIELD_W'(op.wdata);
          if (req.cmd == CMD_PUSH_FRONT) begin
            head_next = (head == '0) ? ADDR_W'(CAPACITY - 1) : head - ADDR_W'(1);
            op.addr   = head_next;
          end else begin
            op.addr = slot_of(head, fill);
          end
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (fill == '0) begin
          res.status = ST_EMPTY;
        end else begin
          op.re       = 1'b1;
          res.use_mem = 1'b1;
          fill_next   = fill - CNT_W'(1);
          if (req.cmd == CMD_POP_FRONT) begin
            op.addr   = head;
            head_next = slot_of(head, CNT_W'(1));
          end else begin
            op.addr = slot_of(head, fill_next);
          end
        end
      end
      default: begin
      end
    endcase
    res.count = fill_next;
  end

  always_comb begin
    ram_req    = op;
    ram_req.we = op.we & take;
    ram_req.re = op.re & take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      fill       <= '0;
      pend.valid <= 1'b0;
    end else begin
      pend.valid <= take;
      if (take) begin
        head          <= head_next;
        fill          <= fill_next;
        pend.use_mem  <= res.use_mem;
        pend.imm_data <= res.imm_data;
        pend.status   <= res.status;
        pend.count    <= res.count;
      end
    end
  end

  a_take_pend: assert property (@(posedge clk) disable iff (rst)
    take |=> pend.valid)
    else $error("accepted transaction did not reach the result stage");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (take && (req.cmd == CMD_PUSH_BACK || req.cmd == CMD_PUSH_FRONT)
     && fill != CNT_W'(CAPACITY)) |=> fill == $past(fill) + CNT_W'(1))
    else $error("push did not grow the fill count");

  a_bounds: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(CAPACITY) && SUM_W'(head) < SUM_W'(CAPACITY))
    else $error("head or fill out of range");

endmodule

// File: sv/circular_deque_indexed.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque_indexed
// fixed-capacity double-ended queue with indexed get and put
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out. The block takes no new command
// while a result is pending: the ring store is read as the command is accepted,
// its data and the pending result are registered and then loaded into the output
// register, so acceptance waits while a result is pending or stalled at the output.
// Pushes on a full queue report full, pops on an empty queue report empty,
// and get or put beyond the current length report an index error; in those
// cases the queue is left unchanged and data is zero.
module circular_deque_indexed
  import cdi_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  ram_req_t              ram_req;
  logic [DATA_WIDTH-1:0] rdata;
  pend_t                 pend;

  cdi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .req_stall (req_stall),
    .out_busy  (rsp_valid & rsp_stall),
    .ram_req   (ram_req),
    .pend      (pend)
  );

  cdi_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (pend.valid) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend.valid) begin
      rsp.data   <= pend.use_mem ? FIELD_W'(rdata) : pend.imm_data;
      rsp.status <= pend.status;
      rsp.count  <= CNT_OUT_W'(pend.count);
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    pend.valid |-> !rsp_valid)
    else $error("pending result would overwrite an undelivered transaction");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.count <= CNT_OUT_W'(CAPACITY))
    else $error("reported count above capacity");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != ST_OK) |-> rsp.data == '0)
    else $error("failed command returned nonzero data");

endmodule
